/* rtl/dcfp_pkg.sv */
// shared types and constants of the downlink command frame parser
package dcfp_pkg;

   localparam int ByteWidth   = 8;
   localparam int ValueWidth  = 32;
   localparam int PeriodWidth = 24;
   localparam int CountWidth  = 3;
   localparam int QueueDepth  = 2;
   localparam int QueuePtrW   = 1;
   localparam int QueueCntW   = 2;
   localparam int ReqDataW    = 8;
   localparam int RspDataW    = 48;

   localparam logic [ByteWidth-1:0] CodeGpio   = 8'h04;
   localparam logic [ByteWidth-1:0] CodePeriod = 8'h05;
   localparam logic [ByteWidth-1:0] CodeTime   = 8'h07;

   localparam logic [CountWidth-1:0] GpioPayload  = 3'd1;
   localparam logic [CountWidth-1:0] LongPayload  = 3'd4;

   typedef enum logic [1:0] {
      KIND_GPIO   = 2'd0,
      KIND_PERIOD = 2'd1,
      KIND_TIME   = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      CLASS_GPIO    = 2'd0,
      CLASS_PERIOD  = 2'd1,
      CLASS_TIME    = 2'd2,
      CLASS_UNKNOWN = 2'd3
   } class_type;

   typedef struct packed {
      logic [ByteWidth-1:0] data;
      logic                 start;
      class_type            code_class;
      logic                 gpio_ok;
      logic [1:0]           gpio_num;
      logic                 gpio_level;
   } item_type;

   typedef struct packed {
      kind_type              kind;
      logic [1:0]            gpio_number;
      logic                  gpio_level;
      logic [ByteWidth-1:0]  period_index;
      logic [ValueWidth-1:0] cmd_value;
   } cmd_type;

endpackage

/* rtl/dcfp_front.sv */
// front end: decodes each incoming byte as a possible record type or gpio payload
module dcfp_front
   import dcfp_pkg::*;
(
   input  logic [ByteWidth-1:0] rx_byte,
   input  logic                 frame_start,
   output item_type             item
);

   logic [3:0] nibble;

   always_comb begin
      nibble          = rx_byte[7:4];
      item.data       = rx_byte;
      item.start      = frame_start;
      item.gpio_num   = nibble[1:0];
      item.gpio_level = rx_byte[0];
      item.gpio_ok    = (nibble[3:2] == 2'b00) && (nibble[1:0] != 2'b00);
      unique case (rx_byte)
         CodeGpio:   item.code_class = CLASS_GPIO;
         CodePeriod: item.code_class = CLASS_PERIOD;
         CodeTime:   item.code_class = CLASS_TIME;
         default:    item.code_class = CLASS_UNKNOWN;
      endcase
   end

endmodule

/* rtl/dcfp_queue.sv */
// two-entry item queue between front and back end
module dcfp_queue
   import dcfp_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  item_type push_item,
   output logic     full,
   input  logic     pop,
   output logic     not_empty,
   output item_type pop_item
);

   item_type               entry_ff [QueueDepth];
   logic [QueuePtrW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QueuePtrW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QueueCntW-1:0]   count_ff, count_in;

   assign full      = (count_ff == QueueCntW'(QueueDepth));
   assign not_empty = (count_ff != '0);
   assign pop_item  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

/* rtl/dcfp_back.sv */
// back end: record parser state and registered command output
module dcfp_back
   import dcfp_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     item_valid,
   input  item_type item,
   output logic     item_pop,
   output logic     cmd_valid,
   output cmd_type  cmd,
   input  logic     cmd_ready
);

   typedef enum logic [1:0] {
      PH_IDLE    = 2'd0,
      PH_TYPE    = 2'd1,
      PH_PAYLOAD = 2'd2
   } phase_type;

   phase_type             phase_ff, phase_in;
   logic [ByteWidth-1:0]  left_ff, left_in;
   kind_type              rtype_ff, rtype_in;
   logic [CountWidth-1:0] count_ff, count_in;
   logic [ByteWidth-1:0]  index_ff, index_in;
   logic [ValueWidth-1:0] value_ff, value_in;
   logic                  valid_ff, valid_in;
   cmd_type               cmd_ff, cmd_in;
   logic [ValueWidth-1:0] shifted;

   assign item_pop  = item_valid && (!valid_ff || cmd_ready);
   assign cmd_valid = valid_ff;
   assign cmd       = cmd_ff;
   assign shifted   = {value_ff[ValueWidth-ByteWidth-1:0], item.data};

   always_comb begin
      phase_in = phase_ff;
      left_in  = left_ff;
      rtype_in = rtype_ff;
      count_in = count_ff;
      index_in = index_ff;
      value_in = value_ff;
      valid_in = valid_ff && !cmd_ready;
      cmd_in   = cmd_ff;
      if (item_pop) begin
         if (item.start) begin
            left_in  = item.data;
            count_in = '0;
            index_in = '0;
            value_in = '0;
            rtype_in = KIND_GPIO;
            phase_in = (item.data != '0) ? PH_TYPE : PH_IDLE;
         end else begin
            unique case (phase_ff)
               PH_TYPE: begin
                  if (left_ff == '0) begin
                     phase_in = PH_IDLE;
                  end else begin
                     left_in  = left_ff - 1'b1;
                     value_in = '0;
                     index_in = '0;
                     unique case (item.code_class)
                        CLASS_GPIO: begin
                           rtype_in = KIND_GPIO;
                           count_in = GpioPayload;
                           phase_in = PH_PAYLOAD;
                        end
                        CLASS_PERIOD: begin
                           rtype_in = KIND_PERIOD;
                           count_in = LongPayload;
                           phase_in = PH_PAYLOAD;
                        end
                        CLASS_TIME: begin
                           rtype_in = KIND_TIME;
                           count_in = LongPayload;
                           phase_in = PH_PAYLOAD;
                        end
                        default: phase_in = PH_IDLE;
                     endcase
                  end
               end
               PH_PAYLOAD: begin
                  if (left_ff != '0) begin
                     left_in = left_ff - 1'b1;
                  end
                  if (rtype_ff == KIND_GPIO) begin
                     count_in = '0;
                     phase_in = PH_TYPE;
                     if (item.gpio_ok) begin
                        valid_in           = 1'b1;
                        cmd_in.kind        = KIND_GPIO;
                        cmd_in.gpio_number = item.gpio_num;
                        cmd_in.gpio_level  = item.gpio_level;
                        cmd_in.period_index = '0;
                        cmd_in.cmd_value   = '0;
                     end
                  end else begin
                     if (rtype_ff == KIND_PERIOD && count_ff == LongPayload) begin
                        index_in = item.data;
                     end else begin
                        value_in = shifted;
                     end
                     count_in = count_ff - 1'b1;
                     if (count_ff == CountWidth'(1)) begin
                        phase_in            = PH_TYPE;
                        valid_in            = 1'b1;
                        cmd_in.kind         = rtype_ff;
                        cmd_in.gpio_number  = '0;
                        cmd_in.gpio_level   = 1'b0;
                        if (rtype_ff == KIND_PERIOD) begin
                           cmd_in.period_index = index_ff;
                           cmd_in.cmd_value    = {{(ValueWidth-PeriodWidth){1'b0}},
                                                  value_in[PeriodWidth-1:0]};
                        end else begin
                           cmd_in.period_index = '0;
                           cmd_in.cmd_value    = value_in;
                        end
                     end
                  end
               end
               default: phase_in = PH_IDLE;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         left_ff  <= '0;
         rtype_ff <= KIND_GPIO;
         count_ff <= '0;
         index_ff <= '0;
         value_ff <= '0;
         valid_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         left_ff  <= left_in;
         rtype_ff <= rtype_in;
         count_ff <= count_in;
         index_ff <= index_in;
         value_ff <= value_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in;
   end

endmodule

/* rtl/downlink_command_frame_parser.sv */
// top level of the downlink command frame parser
// bytes of a received downlink frame enter on the req_ channel, one item per
// byte, with req_tuser high on the length byte that opens a frame. decoded
// commands leave on the rsp_ channel: gpio set, period table write or clock
// time set, with the command kind on rsp_tuser.
// a two-entry queue sits between the decoding front end and the parser back
// end, the back end updates its record state once per byte, and one byte per
// cycle is sustained while no command is held waiting on rsp_tready.
// a command appears on rsp_ once the byte that completes it has been written
// into the queue and then popped by the parser step into the output register.
// reset empties the queue and the output register and puts the parser in idle,
// waiting for a frame start.
// when rsp_tready is low the held command stays on rsp_; the parser stops, the
// queue fills and req_tready drops once both queue entries are in use.
module downlink_command_frame_parser
   import dcfp_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [ReqDataW-1:0] req_tdata,   // rx_byte[7:0]
   input  logic                req_tuser,   // frame_start
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [RspDataW-1:0] rsp_tdata,   // gpio_number[1:0], gpio_level[2],
                                            // period_index[10:3], cmd_value[42:11]
   output logic [1:0]          rsp_tuser    // cmd_kind[1:0]
);

   item_type front_item;
   item_type queue_item;
   logic     queue_full;
   logic     queue_valid;
   logic     queue_pop;
   logic     push;
   cmd_type  cmd;

   assign req_tready = !queue_full;
   assign push       = req_tvalid && !queue_full;

   dcfp_front u_front (
      .rx_byte     (req_tdata),
      .frame_start (req_tuser),
      .item        (front_item)
   );

   dcfp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (front_item),
      .full      (queue_full),
      .pop       (queue_pop),
      .not_empty (queue_valid),
      .pop_item  (queue_item)
   );

   dcfp_back u_back (
      .clock      (clock),
      .reset      (reset),
      .item_valid (queue_valid),
      .item       (queue_item),
      .item_pop   (queue_pop),
      .cmd_valid  (rsp_tvalid),
      .cmd        (cmd),
      .cmd_ready  (rsp_tready)
   );

   assign rsp_tuser = cmd.kind;
   assign rsp_tdata = {5'b0, cmd.cmd_value, cmd.period_index, cmd.gpio_level,
                       cmd.gpio_number};

endmodule

/* dv/command_checker.sv */
// item monitor, command predictor and scoreboard for the downlink command frame parser
module command_checker
   import dcfp_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   input  logic                req_tready,
   input  logic [ReqDataW-1:0] req_tdata,
   input  logic                req_tuser,
   input  logic                rsp_tvalid,
   input  logic                rsp_tready,
   input  logic [RspDataW-1:0] rsp_tdata,
   input  logic [1:0]          rsp_tuser,
   output int                  fail_count,
   output int                  pending_cmds
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef enum logic [1:0] {
      WAIT_FRAME = 2'd0,
      WANT_TYPE  = 2'd1,
      IN_PAYLOAD = 2'd2
   } parse_step_type;

   parse_step_type  phase;
   logic [8:0]      body_left;
   kind_type        rec_kind;
   logic [2:0]      bytes_due;
   logic [7:0]      held_index;
   logic [31:0]     assembled;
   cmd_type         expected_cmds[$];
   int              errors = 0;

   task automatic parse_byte(input logic [7:0] b, input logic start);
      cmd_type c;
      c = '0;
      if (start) begin
         body_left  = {1'b0, b};
         bytes_due  = '0;
         held_index = '0;
         assembled  = '0;
         rec_kind   = KIND_GPIO;
         phase      = (b != 8'h00) ? WANT_TYPE : WAIT_FRAME;
      end else begin
         case (phase)
            WANT_TYPE: begin
               if (body_left == 9'd0) begin
                  phase = WAIT_FRAME;
               end else begin
                  body_left  = body_left - 9'd1;
                  assembled  = '0;
                  held_index = '0;
                  case (b)
                     CodeGpio: begin
                        rec_kind  = KIND_GPIO;
                        bytes_due = GpioPayload;
                        phase     = IN_PAYLOAD;
                     end
                     CodePeriod: begin
                        rec_kind  = KIND_PERIOD;
                        bytes_due = LongPayload;
                        phase     = IN_PAYLOAD;
                     end
                     CodeTime: begin
                        rec_kind  = KIND_TIME;
                        bytes_due = LongPayload;
                        phase     = IN_PAYLOAD;
                     end
                     default: phase = WAIT_FRAME;
                  endcase
               end
            end
            IN_PAYLOAD: begin
               if (body_left != 9'd0) body_left = body_left - 9'd1;
               if (rec_kind == KIND_GPIO) begin
                  bytes_due = '0;
                  phase     = WANT_TYPE;
                  if (b[7:4] >= 4'd1 && b[7:4] <= 4'd3) begin
                     c.kind        = KIND_GPIO;
                     c.gpio_number = b[5:4];
                     c.gpio_level  = b[0];
                     expected_cmds.push_back(c);
                  end
               end else begin
                  if (rec_kind == KIND_PERIOD && bytes_due == LongPayload) held_index = b;
                  else assembled = {assembled[23:0], b};
                  bytes_due = bytes_due - 3'd1;
                  if (bytes_due == 3'd0) begin
                     phase  = WANT_TYPE;
                     c.kind = rec_kind;
                     if (rec_kind == KIND_PERIOD) begin
                        c.period_index = held_index;
                        c.cmd_value    = {8'h00, assembled[23:0]};
                     end else begin
                        c.cmd_value = assembled;
                     end
                     expected_cmds.push_back(c);
                  end
               end
            end
            default: phase = WAIT_FRAME;
         endcase
      end
   endtask

   task automatic check_command();
      cmd_type want;
      if (expected_cmds.size() == 0) begin
         errors++;
         if (errors <= 10)
            $display("unexpected command: kind %0d data %h", rsp_tuser, rsp_tdata);
      end else begin
         want = expected_cmds.pop_front();
         if (rsp_tuser != want.kind || rsp_tdata[1:0] != want.gpio_number ||
             rsp_tdata[2] != want.gpio_level || rsp_tdata[10:3] != want.period_index ||
             rsp_tdata[42:11] != want.cmd_value) begin
            errors++;
            if (errors <= 10)
               $display("command mismatch: expected kind %0d pin %0d level %0d idx %h val %h, %s",
                        want.kind, want.gpio_number, want.gpio_level, want.period_index,
                        want.cmd_value,
                        $sformatf("got kind %0d pin %0d level %0d idx %h val %h",
                                  rsp_tuser, rsp_tdata[1:0], rsp_tdata[2],
                                  rsp_tdata[10:3], rsp_tdata[42:11]));
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         phase      = WAIT_FRAME;
         body_left  = '0;
         rec_kind   = KIND_GPIO;
         bytes_due  = '0;
         held_index = '0;
         assembled  = '0;
      end else begin
         if (req_tvalid && req_tready) parse_byte(req_tdata, req_tuser);
         if (rsp_tvalid && rsp_tready) check_command();
      end
      fail_count   <= errors;
      pending_cmds <= expected_cmds.size();
   end

endmodule

/* dv/testbench.sv */
// top of the downlink command frame parser testbench: clock, reset, byte stimulus, verdict
module testbench;
   import dcfp_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   logic                clock      = 1'b0;
   logic                reset      = 1'b1;
   logic                req_tvalid = 1'b0;
   logic                req_tready;
   logic [ReqDataW-1:0] req_tdata  = '0;
   logic                req_tuser  = 1'b0;
   logic                rsp_tvalid;
   logic                rsp_tready = 1'b0;
   logic [RspDataW-1:0] rsp_tdata;
   logic [1:0]          rsp_tuser;
   int                  fail_count;
   int                  pending_cmds;
   int                  send_idle  = 0;
   int                  recv_idle  = 0;
   int                  bytes_sent = 0;

   downlink_command_frame_parser u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   command_checker u_checker (
      .clock        (clock),
      .reset        (reset),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .req_tdata    (req_tdata),
      .req_tuser    (req_tuser),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_tdata    (rsp_tdata),
      .rsp_tuser    (rsp_tuser),
      .fail_count   (fail_count),
      .pending_cmds (pending_cmds)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_idle);
   end

   task automatic send_byte(input logic [7:0] b, input logic start);
      while ($urandom_range(99) < send_idle) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tuser  <= start;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      bytes_sent++;
   endtask

   task automatic wait_all_commands();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_cmds != 0) @(posedge clock);
   endtask

   task automatic send_random_frame();
      logic [7:0] body[$];
      logic [7:0] pay;
      int         len;
      int         cut;
      int         mode;
      repeat ($urandom_range(1, 4)) begin
         case ($urandom_range(0, 9))
            0, 1, 2: begin
               pay = 8'($urandom);
               pay[7:4] = 4'(($urandom_range(0, 4) == 0) ? $urandom_range(0, 15)
                                                         : $urandom_range(1, 3));
               body.push_back(CodeGpio);
               body.push_back(pay);
            end
            3, 4, 5: begin
               body.push_back(CodePeriod);
               repeat (4) body.push_back(8'($urandom));
            end
            6, 7, 8: begin
               body.push_back(CodeTime);
               repeat (4) body.push_back(8'($urandom));
            end
            default: begin
               do pay = 8'($urandom);
               while (pay == CodeGpio || pay == CodePeriod || pay == CodeTime);
               body.push_back(pay);
               repeat ($urandom_range(0, 3)) body.push_back(8'($urandom));
            end
         endcase
      end
      mode = $urandom_range(0, 9);
      case (mode)
         7:       len = $urandom_range(0, body.size());
         8:       len = body.size() + $urandom_range(1, 5);
         9:       len = $urandom_range(0, 255);
         default: len = body.size();
      endcase
      if (len > 255) len = 255;
      cut = ($urandom_range(0, 9) == 0) ? $urandom_range(0, body.size()) : body.size();
      send_byte(len[7:0], 1'b1);
      for (int i = 0; i < cut; i++) send_byte(body[i], 1'b0);
      if ($urandom_range(0, 5) == 0)
         repeat ($urandom_range(1, 3)) send_byte(8'($urandom), 1'b0);
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // an idle byte, zero length, then a full frame of every record kind
      send_byte(CodeGpio, 1'b0);
      send_byte(8'h00, 1'b1);
      send_byte(8'hff, 1'b1);
      send_byte(CodeGpio, 1'b0);
      send_byte(8'h31, 1'b0);
      send_byte(CodeGpio, 1'b0);
      send_byte(8'h40, 1'b0);
      send_byte(CodePeriod, 1'b0);
      repeat (4) send_byte(8'hff, 1'b0);
      send_byte(CodeTime, 1'b0);
      repeat (4) send_byte(8'h00, 1'b0);
      // payload running past the body, then a byte after the body
      send_byte(8'h01, 1'b1);
      send_byte(CodeTime, 1'b0);
      repeat (4) send_byte(8'hff, 1'b0);
      send_byte(8'h03, 1'b0);
      // new frame mid record, unknown type, ignored tail
      send_byte(8'h03, 1'b1);
      send_byte(CodePeriod, 1'b0);
      send_byte(8'h12, 1'b0);
      send_byte(8'h02, 1'b1);
      send_byte(8'hfe, 1'b0);
      send_byte(CodeGpio, 1'b0);
      wait_all_commands();

      send_idle = 25;
      recv_idle = 62;
      while (bytes_sent < 140) send_random_frame();
      wait_all_commands();

      send_idle = 62;
      recv_idle = 25;
      while (bytes_sent < 260) send_random_frame();
      wait_all_commands();

      send_idle = 0;
      recv_idle = 0;
      while (bytes_sent < 375) send_random_frame();
      wait_all_commands();

      repeat (10) @(posedge clock);
      if (fail_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   initial begin
      #(2_000_000);
      $display("tb: failure");
      $finish;
   end

endmodule
